/* rtl/core/cpba_pkg.sv */
// cpba_pkg: shared constants, types and helper functions for the
// channel power block average core; no dependencies

package cpba_pkg;

   // frame geometry
   localparam int SAMPLES_PER_FRAME = 3072;
   localparam int NUM_LANES         = 3;
   localparam int LANE_SAMPLES      = SAMPLES_PER_FRAME / NUM_LANES;
   localparam int FRAME_LEN         = LANE_SAMPLES * NUM_LANES;
   localparam int MAX_AVERAGE       = 16;

   // field and state widths
   localparam int SAMPLE_W   = 12;
   localparam int PRODUCT_W  = 2 * SAMPLE_W;
   localparam int LEVEL_W    = 16;
   localparam int CHAN_W     = 2;
   localparam int LANE_W     = 2;
   localparam int CNT_W      = 12;
   localparam int SUM_W      = 40;
   localparam int AVG_LEN_W  = 5;
   localparam int AVG_SUM_W  = 21;
   localparam int QUOT_W     = 20;
   localparam int DIV_CNT_W  = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // frame / lane / result markers
   localparam logic [CNT_W-1:0]     FRAME_LAST  = CNT_W'(FRAME_LEN - 1);
   localparam logic [LANE_W-1:0]    LANE_FIRST  = LANE_W'(0);
   localparam logic [LANE_W-1:0]    LANE_LAST   = LANE_W'(NUM_LANES - 1);
   localparam logic [CHAN_W-1:0]    RESULT_LAST = CHAN_W'(NUM_LANES - 1);
   localparam logic [AVG_LEN_W-1:0] AVG_LEN_MAX = AVG_LEN_W'(MAX_AVERAGE);
   localparam logic [AVG_LEN_W-1:0] AVG_BYPASS  = AVG_LEN_W'(1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(QUOT_W - 1);

   // saturation limits
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (LEVEL_W - 1) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(2 ** (LEVEL_W - 1));

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SQUARE_MODE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_LENGTH = CSR_IDX_W'(1);

   // front to back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // three per-lane levels of one frame
   typedef logic [NUM_LANES-1:0][LEVEL_W-1:0] frame_vals_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV_START,
      BACK_DIV_WAIT,
      BACK_EMIT
   } back_state_type;

   function automatic logic [LEVEL_W-1:0] sat_level(input logic signed [SUM_W-1:0] v);
      logic [LEVEL_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[LEVEL_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[LEVEL_W-1:0];
      end else begin
         r = v[LEVEL_W-1:0];
      end
      return r;
   endfunction

   // physical remap: result 0 is lane 1, result 1 is lane 0, result 2 is lane 2
   function automatic logic [LANE_W-1:0] lane_of_result(input logic [CHAN_W-1:0] k);
      logic [LANE_W-1:0] r;
      case (k)
         CHAN_W'(0): r = LANE_W'(1);
         CHAN_W'(1): r = LANE_W'(0);
         default:    r = LANE_W'(2);
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/cpba_front.sv */
// cpba_front: sample accumulator, per-lane frame sums and frame level
// generation; depends on cpba_pkg

module cpba_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [cpba_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_frame_start,
   input  logic                                 square_mode,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output cpba_pkg::frame_vals_type             push_data
);

   logic signed [cpba_pkg::SUM_W-1:0]     frame_sums_ff [cpba_pkg::NUM_LANES];
   logic signed [cpba_pkg::SUM_W-1:0]     frame_sums_in [cpba_pkg::NUM_LANES];
   logic        [cpba_pkg::CNT_W-1:0]     counter_ff, counter_in;
   logic        [cpba_pkg::LANE_W-1:0]    lane_ff, lane_in;
   logic                                  done_ff, done_in;

   logic signed [cpba_pkg::PRODUCT_W-1:0] product;
   logic signed [cpba_pkg::SUM_W-1:0]     term;
   logic signed [cpba_pkg::SUM_W-1:0]     base;
   logic signed [cpba_pkg::SUM_W-1:0]     quot [cpba_pkg::NUM_LANES];
   logic        [cpba_pkg::CNT_W-1:0]     counter_eff;
   logic        [cpba_pkg::LANE_W-1:0]    lane_eff;
   logic                                  accepted;

   assign req_ready  = !done_ff;
   assign push_valid = done_ff;
   assign accepted   = req_valid && req_ready;

   always_comb begin
      for (int j = 0; j < cpba_pkg::NUM_LANES; j++) begin
         quot[j]      = frame_sums_ff[j] / cpba_pkg::SUM_W'(cpba_pkg::LANE_SAMPLES);
         push_data[j] = cpba_pkg::sat_level(quot[j]);
      end
   end

   always_comb begin
      product     = req_sample * req_sample;
      term        = square_mode ? cpba_pkg::SUM_W'(product) : cpba_pkg::SUM_W'(req_sample);
      lane_eff    = req_frame_start ? cpba_pkg::LANE_FIRST : lane_ff;
      counter_eff = req_frame_start ? '0 : counter_ff;

      frame_sums_in = frame_sums_ff;
      counter_in    = counter_ff;
      lane_in       = lane_ff;
      done_in       = done_ff;
      base          = '0;

      if (done_ff) begin
         if (push_ready) begin
            for (int j = 0; j < cpba_pkg::NUM_LANES; j++) begin
               frame_sums_in[j] = '0;
            end
            done_in = 1'b0;
         end
      end else if (accepted) begin
         for (int j = 0; j < cpba_pkg::NUM_LANES; j++) begin
            base = req_frame_start ? '0 : frame_sums_ff[j];
            if (lane_eff == cpba_pkg::LANE_W'(j)) begin
               frame_sums_in[j] = base + term;
            end else begin
               frame_sums_in[j] = base;
            end
         end
         if (counter_eff == cpba_pkg::FRAME_LAST) begin
            counter_in = '0;
            lane_in    = cpba_pkg::LANE_FIRST;
            done_in    = 1'b1;
         end else begin
            counter_in = counter_eff + cpba_pkg::CNT_W'(1);
            lane_in    = (lane_eff == cpba_pkg::LANE_LAST) ? cpba_pkg::LANE_FIRST
                                                            : lane_eff + cpba_pkg::LANE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < cpba_pkg::NUM_LANES; j++) begin
            frame_sums_ff[j] <= '0;
         end
         counter_ff <= '0;
         lane_ff    <= cpba_pkg::LANE_FIRST;
         done_ff    <= 1'b0;
      end else begin
         frame_sums_ff <= frame_sums_in;
         counter_ff    <= counter_in;
         lane_ff       <= lane_in;
         done_ff       <= done_in;
      end
   end

endmodule

/* rtl/core/cpba_queue.sv */
// cpba_queue: two-entry queue of frame levels between front and back
// depends on cpba_pkg

module cpba_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  cpba_pkg::frame_vals_type push_data,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output cpba_pkg::frame_vals_type pop_data
);

   cpba_pkg::frame_vals_type             entry_ff [cpba_pkg::QUEUE_DEPTH];
   logic [cpba_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [cpba_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [cpba_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                                 do_push, do_pop;

   assign push_ready = (count_ff != cpba_pkg::QUEUE_CNT_W'(cpba_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + cpba_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + cpba_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + cpba_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - cpba_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/cpba_div.sv */
// cpba_div: restoring divider, one quotient bit per cycle
// depends on cpba_pkg

module cpba_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [cpba_pkg::QUOT_W-1:0]        dividend,
   input  logic [cpba_pkg::AVG_LEN_W-1:0]     divisor,
   output logic                               done,
   output logic [cpba_pkg::QUOT_W-1:0]        quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [cpba_pkg::DIV_CNT_W-1:0]    count_ff, count_in;
   logic [cpba_pkg::QUOT_W-1:0]       dvd_ff, dvd_in;
   logic [cpba_pkg::AVG_LEN_W-1:0]    rem_ff, rem_in;
   logic [cpba_pkg::AVG_LEN_W-1:0]    divisor_ff, divisor_in;
   logic [cpba_pkg::AVG_LEN_W:0]      rem_shift;
   logic [cpba_pkg::AVG_LEN_W:0]      rem_diff;
   logic                              q_bit;

   assign done     = done_ff;
   assign quotient = dvd_ff;

   always_comb begin
      rem_shift  = {rem_ff, dvd_ff[cpba_pkg::QUOT_W-1]};
      rem_diff   = rem_shift - {1'b0, divisor_ff};
      q_bit      = (rem_shift >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         dvd_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = q_bit ? rem_diff[cpba_pkg::AVG_LEN_W-1:0]
                          : rem_shift[cpba_pkg::AVG_LEN_W-1:0];
         dvd_in   = {dvd_ff[cpba_pkg::QUOT_W-2:0], q_bit};
         count_in = count_ff + cpba_pkg::DIV_CNT_W'(1);
         if (count_ff == cpba_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/core/cpba_back.sv */
// cpba_back: block averaging over frames, division by the average length
// and result emission; depends on cpba_pkg and cpba_div

module cpba_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [cpba_pkg::AVG_LEN_W-1:0]       average_length,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  cpba_pkg::frame_vals_type             pop_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cpba_pkg::CHAN_W-1:0]          rsp_channel_index,
   output logic signed [cpba_pkg::LEVEL_W-1:0]  rsp_level,
   output logic                                 rsp_last_of_set
);

   cpba_pkg::back_state_type            state_ff, state_in;
   logic signed [cpba_pkg::AVG_SUM_W-1:0] avg_sums_ff [cpba_pkg::NUM_LANES];
   logic signed [cpba_pkg::AVG_SUM_W-1:0] avg_sums_in [cpba_pkg::NUM_LANES];
   logic [cpba_pkg::AVG_LEN_W-1:0]      collected_ff, collected_in;
   logic [cpba_pkg::AVG_LEN_W-1:0]      len_ff, len_in;
   logic [cpba_pkg::LEVEL_W-1:0]        levels_ff [cpba_pkg::NUM_LANES];
   logic [cpba_pkg::LEVEL_W-1:0]        levels_in [cpba_pkg::NUM_LANES];
   logic [cpba_pkg::LANE_W-1:0]         lane_ff, lane_in;
   logic [cpba_pkg::CHAN_W-1:0]         result_ff, result_in;

   logic [cpba_pkg::AVG_LEN_W-1:0]      len_now;
   logic [cpba_pkg::AVG_LEN_W-1:0]      collected_next;
   logic signed [cpba_pkg::AVG_SUM_W-1:0] avg_sel;
   logic signed [cpba_pkg::AVG_SUM_W-1:0] avg_mag;
   logic signed [cpba_pkg::SUM_W-1:0]   q_mag;
   logic signed [cpba_pkg::SUM_W-1:0]   q_signed;
   logic                                avg_neg;
   logic                                div_start;
   logic                                div_done;
   logic [cpba_pkg::QUOT_W-1:0]         div_quotient;

   cpba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (avg_mag[cpba_pkg::QUOT_W-1:0]),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign pop_ready         = (state_ff == cpba_pkg::BACK_IDLE);
   assign rsp_valid         = (state_ff == cpba_pkg::BACK_EMIT);
   assign rsp_channel_index = result_ff;
   assign rsp_level         = levels_ff[cpba_pkg::lane_of_result(result_ff)];
   assign rsp_last_of_set   = (result_ff == cpba_pkg::RESULT_LAST);

   always_comb begin
      len_now        = (average_length > cpba_pkg::AVG_LEN_MAX) ? cpba_pkg::AVG_LEN_MAX
                                                                : average_length;
      collected_next = collected_ff + cpba_pkg::AVG_LEN_W'(1);
      avg_sel        = avg_sums_ff[lane_ff];
      avg_neg        = avg_sel[cpba_pkg::AVG_SUM_W-1];
      avg_mag        = avg_neg ? -avg_sel : avg_sel;
      q_mag          = cpba_pkg::SUM_W'(div_quotient);
      q_signed       = avg_neg ? -q_mag : q_mag;

      state_in     = state_ff;
      avg_sums_in  = avg_sums_ff;
      collected_in = collected_ff;
      len_in       = len_ff;
      levels_in    = levels_ff;
      lane_in      = lane_ff;
      result_in    = result_ff;
      div_start    = 1'b0;

      case (state_ff)
         cpba_pkg::BACK_IDLE: begin
            if (pop_valid) begin
               if (len_now <= cpba_pkg::AVG_BYPASS) begin
                  for (int j = 0; j < cpba_pkg::NUM_LANES; j++) begin
                     levels_in[j]   = pop_data[j];
                     avg_sums_in[j] = '0;
                  end
                  collected_in = '0;
                  result_in    = '0;
                  state_in     = cpba_pkg::BACK_EMIT;
               end else begin
                  for (int j = 0; j < cpba_pkg::NUM_LANES; j++) begin
                     avg_sums_in[j] = avg_sums_ff[j]
                                    + cpba_pkg::AVG_SUM_W'($signed(pop_data[j]));
                  end
                  collected_in = collected_next;
                  if (collected_next >= len_now) begin
                     len_in   = len_now;
                     lane_in  = cpba_pkg::LANE_FIRST;
                     state_in = cpba_pkg::BACK_DIV_START;
                  end
               end
            end
         end
         cpba_pkg::BACK_DIV_START: begin
            div_start = 1'b1;
            state_in  = cpba_pkg::BACK_DIV_WAIT;
         end
         cpba_pkg::BACK_DIV_WAIT: begin
            if (div_done) begin
               levels_in[lane_ff] = cpba_pkg::sat_level(q_signed);
               if (lane_ff == cpba_pkg::LANE_LAST) begin
                  for (int j = 0; j < cpba_pkg::NUM_LANES; j++) begin
                     avg_sums_in[j] = '0;
                  end
                  collected_in = '0;
                  result_in    = '0;
                  state_in     = cpba_pkg::BACK_EMIT;
               end else begin
                  lane_in  = lane_ff + cpba_pkg::LANE_W'(1);
                  state_in = cpba_pkg::BACK_DIV_START;
               end
            end
         end
         cpba_pkg::BACK_EMIT: begin
            if (rsp_ready) begin
               if (result_ff == cpba_pkg::RESULT_LAST) begin
                  state_in = cpba_pkg::BACK_IDLE;
               end else begin
                  result_in = result_ff + cpba_pkg::CHAN_W'(1);
               end
            end
         end
         default: begin
            state_in = cpba_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
      len_ff    <= len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpba_pkg::BACK_IDLE;
         for (int j = 0; j < cpba_pkg::NUM_LANES; j++) begin
            avg_sums_ff[j] <= '0;
         end
         collected_ff <= '0;
         lane_ff      <= cpba_pkg::LANE_FIRST;
         result_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         avg_sums_ff  <= avg_sums_in;
         collected_ff <= collected_in;
         lane_ff      <= lane_in;
         result_ff    <= result_in;
      end
   end

endmodule

/* rtl/core/channel_power_block_average_core.sv */
// channel_power_block_average_core: top level of the three-channel power detector
// depends on cpba_pkg, cpba_front, cpba_queue and cpba_back
//
// throughput: one sample request per cycle, but requests stall at each frame end until
//    the queue takes the frame (longer only if two finished frames already wait in it)
// results: with averaging bypassed, frame levels go from the queue straight to emission;
//    a completed block average is divided lane by lane in the bit-serial divider shared
//    by the three lanes
// reset: synchronous, clears the sums, counters, queue and both registers to zero

module channel_power_block_average_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample requests
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [cpba_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_frame_start,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cpba_pkg::CHAN_W-1:0]          rsp_channel_index,
   output logic signed [cpba_pkg::LEVEL_W-1:0]  rsp_level,
   output logic                                 rsp_last_of_set,
   // register writes
   input  logic                                 csr_write,
   input  logic [cpba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cpba_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration registers
   logic                              square_mode_ff, square_mode_in;
   logic [cpba_pkg::AVG_LEN_W-1:0]    average_length_ff, average_length_in;

   // front to queue
   logic                              push_valid;
   logic                              push_ready;
   cpba_pkg::frame_vals_type          push_data;

   // queue to back
   logic                              pop_valid;
   logic                              pop_ready;
   cpba_pkg::frame_vals_type          pop_data;

   // register write decode, unknown indexes are dropped
   always_comb begin
      square_mode_in    = square_mode_ff;
      average_length_in = average_length_ff;
      if (csr_write) begin
         case (csr_index)
            cpba_pkg::CSR_SQUARE_MODE: begin
               square_mode_in = csr_wdata[0];
            end
            cpba_pkg::CSR_AVERAGE_LENGTH: begin
               average_length_in = csr_wdata[cpba_pkg::AVG_LEN_W-1:0];
            end
            default: begin
               square_mode_in = square_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         square_mode_ff    <= 1'b0;
         average_length_ff <= '0;
      end else begin
         square_mode_ff    <= square_mode_in;
         average_length_ff <= average_length_in;
      end
   end

   // front: per-lane accumulation and frame levels
   cpba_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .square_mode     (square_mode_ff),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   // short queue so the front keeps sampling while results drain
   cpba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: block averaging, division and result emission in order 1, 0, 2
   cpba_back u_back (
      .clock             (clock),
      .reset             (reset),
      .average_length    (average_length_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_index (rsp_channel_index),
      .rsp_level         (rsp_level),
      .rsp_last_of_set   (rsp_last_of_set)
   );

endmodule
